// ----- src/virtio_mmio_register_front_end_core_assert.svh -----
// assertion macros for the virtio-mmio front end
`ifndef VIRTIO_MMIO_REGISTER_FRONT_END_CORE_ASSERT_SVH
`define VIRTIO_MMIO_REGISTER_FRONT_END_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define VMMIO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define VMMIO_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VMMIO_ASSERT(lbl, prop, msg)
`define VMMIO_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- src/vmmio_pkg.sv -----
`timescale 1ns / 1ps

package vmmio_pkg;

    localparam int NUM_QUEUES_DEF     = 8;
    localparam int QUEUE_MAX_SIZE_DEF = 256;
    localparam int CFG_IDX_W          = 3;

    // item kinds
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_RAISE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VENDOR_ID         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_FEATURES_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_FEATURES_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUES_IN_USE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FEATURES_ACCEPTED = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIG_GENERATION = 3'd6;

    localparam logic [31:0] MMIO_MAGIC   = 32'h7472_6976;
    localparam logic [31:0] MMIO_VERSION = 32'd2;

    // status handshake bits, as new-bit patterns
    localparam logic [31:0] ST_NONE      = 32'h00;
    localparam logic [31:0] ST_ACK       = 32'h01;
    localparam logic [31:0] ST_DRIVER    = 32'h02;
    localparam logic [31:0] ST_DRIVER_OK = 32'h04;
    localparam logic [31:0] ST_FEAT_OK   = 32'h08;
    localparam logic [31:0] ST_FAILED    = 32'h80;

    // per-queue register held in the ring memory
    typedef enum logic [2:0] {
        RING_QNUM,
        RING_DESC_LO,
        RING_DESC_HI,
        RING_AVAIL_LO,
        RING_AVAIL_HI,
        RING_USED_LO,
        RING_USED_HI
    } ring_field_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] offset;
        logic [31:0] wdata;
    } item_t;

    typedef struct packed {
        logic [31:0] rdata;
        logic        ok;
        logic        notify_pulse;
        logic [31:0] notify_value;
        logic        reset_pulse;
    } result_t;

    typedef struct packed {
        logic [31:0] device_id;
        logic [31:0] vendor_id;
        logic [31:0] device_features_low;
        logic [31:0] device_features_high;
        logic [3:0]  queues_in_use;
        logic        features_accepted;
        logic [31:0] config_generation;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  device_status;
        logic [31:0] interrupt_status;
        logic [31:0] device_feature_select;
        logic [31:0] driver_feature_select;
        logic [31:0] driver_features_0;
        logic [31:0] driver_features_1;
        logic [31:0] queue_select;
        logic [31:0] notify_latch;
    } core_state_t;

endpackage

// ----- src/vmmio_if.sv -----
`timescale 1ns / 1ps

// request channel
interface vmmio_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [11:0] offset;
    logic [31:0] wdata;

    modport source (output valid, output mode, output offset, output wdata, input ready);
    modport sink (input valid, input mode, input offset, input wdata, output ready);
endinterface

// response channel
interface vmmio_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] rdata;
    logic        ok;
    logic        notify_pulse;
    logic [31:0] notify_value;
    logic        reset_pulse;

    modport source (output valid, output rdata, output ok, output notify_pulse,
                    output notify_value, output reset_pulse, input ready);
    modport sink (input valid, input rdata, input ok, input notify_pulse,
                  input notify_value, input reset_pulse, output ready);
endinterface

// ----- src/vmmio_ram.sv -----
`timescale 1ns / 1ps

module vmmio_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/vmmio_exec.sv -----
`timescale 1ns / 1ps

// register decode and state update for one item
module vmmio_exec #(
    parameter int NUM_QUEUES     = vmmio_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_MAX_SIZE = vmmio_pkg::QUEUE_MAX_SIZE_DEF,
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
    input  vmmio_pkg::item_t         item,
    input  vmmio_pkg::cfg_t          cfg,
    input  vmmio_pkg::core_state_t   st,
    input  logic [NUM_QUEUES-1:0]    qready,
    output vmmio_pkg::core_state_t   st_next,
    output logic [NUM_QUEUES-1:0]    qready_next,
    output vmmio_pkg::result_t       res,
    output logic                     ring_we,
    output logic [QW-1:0]            ring_queue,
    output vmmio_pkg::ring_field_t   ring_field
);

    logic [31:0] q_limit;
    logic        sel_valid;
    logic [QW-1:0] q;
    logic        q_ready;
    logic [11:0] off;
    logic [31:0] d;
    logic [7:0]  st_and;
    logic [31:0] fresh;

    always_comb
    begin
        off = item.offset;
        d   = item.wdata;

        q_limit = (32'(cfg.queues_in_use) > 32'(NUM_QUEUES)) ?
                  32'(NUM_QUEUES) : 32'(cfg.queues_in_use);
        sel_valid = st.queue_select < q_limit;
        q = sel_valid ? st.queue_select[QW-1:0] : '0;
        q_ready = qready[q];

        st_and = st.device_status & d[7:0];
        fresh  = d & ~{24'h0, st_and};

        st_next     = st;
        qready_next = qready;
        res         = '0;
        ring_we     = 1'b0;
        ring_queue  = q;
        ring_field  = vmmio_pkg::RING_QNUM;

        case (item.mode)
            vmmio_pkg::MODE_READ:
            begin
                res.ok = 1'b1;
                if (off inside {[12'h000:12'h003]})
                    res.rdata = vmmio_pkg::MMIO_MAGIC;
                else if (off inside {[12'h004:12'h007]})
                    res.rdata = vmmio_pkg::MMIO_VERSION;
                else if (off inside {[12'h008:12'h00B]})
                    res.rdata = cfg.device_id;
                else if (off inside {[12'h00C:12'h00F]})
                    res.rdata = cfg.vendor_id;
                else if (off inside {[12'h010:12'h013]})
                begin
                    if (st.device_feature_select == 32'd0)
                        res.rdata = cfg.device_features_low;
                    else if (st.device_feature_select == 32'd1)
                        res.rdata = cfg.device_features_high;
                    else
                        res.ok = 1'b0;
                end
                else if (off inside {[12'h034:12'h037]})
                    res.rdata = 32'(QUEUE_MAX_SIZE);
                else if (off inside {[12'h044:12'h04F]})
                begin
                    if (sel_valid)
                        res.rdata = {31'h0, q_ready};
                    else
                        res.ok = 1'b0;
                end
                else if (off inside {[12'h060:12'h063]})
                    res.rdata = st.interrupt_status;
                else if (off inside {[12'h070:12'h07F]})
                    res.rdata = {24'h0, st.device_status};
                else if (off inside {[12'h0FC:12'h0FF]})
                    res.rdata = cfg.config_generation;
                else
                    res.ok = 1'b0;
            end
            vmmio_pkg::MODE_WRITE:
            begin
                res.ok = 1'b1;
                if (sel_valid && q_ready &&
                    (off inside {[12'h038:12'h043], [12'h080:12'h0FB]}))
                    res.ok = 1'b0;
                else if (off inside {[12'h014:12'h01F]})
                    st_next.device_feature_select = d;
                else if (off inside {[12'h020:12'h023]})
                begin
                    if (st.driver_feature_select > 32'd1)
                        res.ok = 1'b0;
                    else if (st.driver_feature_select[0])
                        st_next.driver_features_1 = d;
                    else
                        st_next.driver_features_0 = d;
                end
                else if (off inside {[12'h024:12'h02F]})
                    st_next.driver_feature_select = d;
                else if (off inside {[12'h030:12'h033]})
                    st_next.queue_select = d;
                else if (off inside {[12'h038:12'h043]})
                begin
                    if (sel_valid)
                        ring_we = 1'b1;
                    else
                        res.ok = 1'b0;
                end
                else if (off inside {[12'h044:12'h04F]})
                begin
                    // only a write of one does anything
                    if (d == 32'd1)
                    begin
                        if (sel_valid)
                            qready_next[q] = 1'b1;
                        else
                            res.ok = 1'b0;
                    end
                end
                else if (off inside {[12'h050:12'h05F]})
                begin
                    st_next.notify_latch = d;
                    res.notify_pulse     = 1'b1;
                    res.notify_value     = d;
                end
                else if (off inside {[12'h064:12'h06F]})
                    st_next.interrupt_status = st.interrupt_status & ~d;
                else if (off inside {[12'h070:12'h07F]})
                begin
                    st_next.device_status = st_and;
                    case (fresh)
                        vmmio_pkg::ST_NONE:
                        begin
                            st_next.device_status    = 8'h0;
                            st_next.interrupt_status = 32'h0;
                            qready_next              = '0;
                            res.reset_pulse          = 1'b1;
                        end
                        vmmio_pkg::ST_ACK:
                            if (st_and == 8'h0)
                                st_next.device_status = st_and | vmmio_pkg::ST_ACK[7:0];
                        vmmio_pkg::ST_DRIVER:
                            if ((st_and & vmmio_pkg::ST_ACK[7:0]) != 8'h0)
                                st_next.device_status = st_and | vmmio_pkg::ST_DRIVER[7:0];
                        vmmio_pkg::ST_FEAT_OK:
                            if (((st_and & vmmio_pkg::ST_DRIVER[7:0]) != 8'h0) &&
                                cfg.features_accepted)
                                st_next.device_status = st_and | vmmio_pkg::ST_FEAT_OK[7:0];
                        vmmio_pkg::ST_DRIVER_OK:
                            st_next.device_status = st_and | vmmio_pkg::ST_DRIVER_OK[7:0];
                        vmmio_pkg::ST_FAILED:
                            res.ok = 1'b1;
                        default:
                            res.ok = 1'b0;
                    endcase
                end
                else if (off inside {[12'h080:12'h0FB]})
                begin
                    if (sel_valid)
                    begin
                        ring_we = 1'b1;
                        if (off inside {[12'h080:12'h083]})
                            ring_field = vmmio_pkg::RING_DESC_LO;
                        else if (off inside {[12'h084:12'h08F]})
                            ring_field = vmmio_pkg::RING_DESC_HI;
                        else if (off inside {[12'h090:12'h093]})
                            ring_field = vmmio_pkg::RING_AVAIL_LO;
                        else if (off inside {[12'h094:12'h09F]})
                            ring_field = vmmio_pkg::RING_AVAIL_HI;
                        else if (off inside {[12'h0A0:12'h0A3]})
                            ring_field = vmmio_pkg::RING_USED_LO;
                        else
                            ring_field = vmmio_pkg::RING_USED_HI;
                    end
                    else
                        res.ok = 1'b0;
                end
                else
                    res.ok = 1'b0;
            end
            vmmio_pkg::MODE_RAISE:
            begin
                st_next.interrupt_status = st.interrupt_status | d;
                res.ok = 1'b1;
            end
            default:
                res.ok = 1'b0;
        endcase
    end

endmodule

// ----- src/virtio_mmio_register_front_end_core.sv -----
`timescale 1ns / 1ps

// virtio-mmio (version 2) register front end. each request item is a driver
// read, a driver write or a device interrupt raise, and gives exactly one
// response item carrying read data, an ok flag and the notify and reset
// pulses. an item is captured in an input register, decoded against the
// register window and applied to the register state when the response
// register is loaded; the block takes one item per cycle, and only a
// stalled response slows it. queue sizes and ring addresses live in a
// small memory of eight words per queue; the ready bits, status byte and
// interrupt status are flip-flops cleared by reset and by a driver reset
// through the status register
`include "virtio_mmio_register_front_end_core_assert.svh"

module virtio_mmio_register_front_end_core #(
    parameter int NUM_QUEUES     = vmmio_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_MAX_SIZE = vmmio_pkg::QUEUE_MAX_SIZE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    vmmio_req_if.sink                       req,
    vmmio_rsp_if.source                     rsp,
    input  logic                            cfg_we,
    input  logic [vmmio_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_wdata
);

    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int RING_DEPTH = (2 ** QW) * 8;

    // pipeline registers
    vmmio_pkg::item_t       item_reg;
    logic                   in_v_reg;
    vmmio_pkg::result_t     res_reg;
    logic                   out_v_reg;

    // architectural state
    vmmio_pkg::cfg_t        cfg_reg;
    vmmio_pkg::core_state_t st_reg;
    logic [NUM_QUEUES-1:0]  qready_reg;

    // decode results
    vmmio_pkg::core_state_t st_next;
    logic [NUM_QUEUES-1:0]  qready_next;
    vmmio_pkg::result_t     res_next;
    logic                   ring_we;
    logic [QW-1:0]          ring_queue;
    vmmio_pkg::ring_field_t ring_field;
    logic [QW+2:0]          ring_addr;

    logic                   advance;
    logic                   fire;

    // response slot frees when empty or being taken
    assign advance   = !out_v_reg || rsp.ready;
    assign fire      = in_v_reg && advance;
    assign req.ready = !in_v_reg || advance;

    vmmio_exec #(
        .NUM_QUEUES     (NUM_QUEUES),
        .QUEUE_MAX_SIZE (QUEUE_MAX_SIZE)
    ) u_exec (
        .item        (item_reg),
        .cfg         (cfg_reg),
        .st          (st_reg),
        .qready      (qready_reg),
        .st_next     (st_next),
        .qready_next (qready_next),
        .res         (res_next),
        .ring_we     (ring_we),
        .ring_queue  (ring_queue),
        .ring_field  (ring_field)
    );

    // queue size and ring address halves, eight words per queue
    assign ring_addr = {ring_queue, ring_field};

    vmmio_ram #(
        .WIDTH (32),
        .DEPTH (RING_DEPTH)
    ) u_ring_ram (
        .clk   (clk),
        .we    (fire && ring_we),
        .waddr (ring_addr),
        .wdata (item_reg.wdata),
        .raddr (ring_addr),
        .rdata ()
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg   <= 1'b0;
            out_v_reg  <= 1'b0;
            st_reg     <= '0;
            qready_reg <= '0;
            cfg_reg    <= '{device_id: 32'h0, vendor_id: 32'h0,
                            device_features_low: 32'h0, device_features_high: 32'h0,
                            queues_in_use: 4'd1, features_accepted: 1'b1,
                            config_generation: 32'h0};
        end
        else
        begin
            // input register
            if (req.valid && req.ready)
                in_v_reg <= 1'b1;
            else if (fire)
                in_v_reg <= 1'b0;

            // response register and state update move together
            if (fire)
            begin
                out_v_reg  <= 1'b1;
                st_reg     <= st_next;
                qready_reg <= qready_next;
            end
            else if (rsp.ready)
                out_v_reg <= 1'b0;

            // configuration writes, to be made only while idle; the block does not enforce it
            if (cfg_we)
            begin
                case (cfg_index)
                    vmmio_pkg::CFG_DEVICE_ID:         cfg_reg.device_id <= cfg_wdata;
                    vmmio_pkg::CFG_VENDOR_ID:         cfg_reg.vendor_id <= cfg_wdata;
                    vmmio_pkg::CFG_DEV_FEATURES_LOW:  cfg_reg.device_features_low <= cfg_wdata;
                    vmmio_pkg::CFG_DEV_FEATURES_HIGH: cfg_reg.device_features_high <= cfg_wdata;
                    vmmio_pkg::CFG_QUEUES_IN_USE:     cfg_reg.queues_in_use <= cfg_wdata[3:0];
                    vmmio_pkg::CFG_FEATURES_ACCEPTED: cfg_reg.features_accepted <= cfg_wdata[0];
                    vmmio_pkg::CFG_CONFIG_GENERATION: cfg_reg.config_generation <= cfg_wdata;
                    default:                          cfg_reg <= cfg_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg.mode   <= req.mode;
            item_reg.offset <= req.offset;
            item_reg.wdata  <= req.wdata;
        end
        if (fire)
            res_reg <= res_next;
    end

    assign rsp.valid        = out_v_reg;
    assign rsp.rdata        = res_reg.rdata;
    assign rsp.ok           = res_reg.ok;
    assign rsp.notify_pulse = res_reg.notify_pulse;
    assign rsp.notify_value = res_reg.notify_value;
    assign rsp.reset_pulse  = res_reg.reset_pulse;

    // a driver reset is always a successful write with no read data
    `VMMIO_ASSERT(a_reset_is_ok, rsp.valid && rsp.reset_pulse |-> rsp.ok && rsp.rdata == 32'h0, "reset pulse without ok")
    // status and ready bits are clear right after a driver reset is applied
    `VMMIO_ASSERT(a_reset_clears, fire && res_next.reset_pulse |=> st_reg.device_status == 8'h0 && qready_reg == '0, "driver reset left state behind")
    // notify value only carries data alongside the pulse
    `VMMIO_ASSERT(a_notify_value, rsp.valid && !rsp.notify_pulse |-> rsp.notify_value == 32'h0, "notify value without pulse")
    // a full pipe with a stalled response takes nothing new
    `VMMIO_ASSERT_ALWAYS(a_full_stall, rst_n && in_v_reg && out_v_reg && !rsp.ready |-> !req.ready, "item taken into full pipe")

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import vmmio_pkg::*;

    localparam int NQ = NUM_QUEUES_DEF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    vmmio_req_if req ();
    vmmio_rsp_if rsp ();

    virtio_mmio_register_front_end_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req.sink),
        .rsp      (rsp.source),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    // 10 ns clock
    always #5 clk = ~clk;

    // generous fixed limit on the whole run
    initial
    begin
        #20ms;
        $display("testbench: done, errors");
        $finish;
    end

    // ---------------------------------------------------------------
    // predictor state: a shadow copy of the register file and its setup
    // ---------------------------------------------------------------
    cfg_t        shadow_cfg;
    logic [7:0]  sh_status;
    logic [31:0] sh_irq;
    logic [31:0] sh_dev_fsel;
    logic [31:0] sh_drv_fsel;
    logic [31:0] sh_drv_feat [2];
    logic [31:0] sh_qsel;
    logic [31:0] sh_notify;
    logic        sh_qready [NQ];
    logic [31:0] sh_qlen [NQ];
    logic [63:0] sh_desc [NQ];
    logic [63:0] sh_avail [NQ];
    logic [63:0] sh_used [NQ];

    // expected responses, oldest first
    result_t rsp_expected [$];
    int errors = 0;
    int items_sent = 0;
    int rsp_checked = 0;

    // idling controls, in percent of cycles
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    bit long_hold_req = 0;

    // typed expectation riding along with the item currently offered
    bit      cur_typed = 0;
    result_t cur_exp;

    function automatic bit shadow_sel_valid();
        logic [31:0] n;
        n = (shadow_cfg.queues_in_use < NQ) ? 32'(shadow_cfg.queues_in_use) : NQ;
        return sh_qsel < n;
    endfunction

    // status handshake; returns the ok flag
    function automatic bit shadow_status_write(logic [31:0] d, ref bit rst);
        logic [31:0] cur;
        logic [31:0] fresh;
        cur = {24'd0, sh_status} & d;
        sh_status = cur[7:0];
        fresh = d & ~cur;
        case (fresh)
            ST_NONE:
            begin
                sh_status = '0;
                sh_irq = '0;
                foreach (sh_qready[i]) sh_qready[i] = 1'b0;
                rst = 1;
                return 1;
            end
            ST_ACK:
            begin
                if (sh_status == 0) sh_status = sh_status | ST_ACK[7:0];
                return 1;
            end
            ST_DRIVER:
            begin
                if (sh_status & ST_ACK[7:0]) sh_status = sh_status | ST_DRIVER[7:0];
                return 1;
            end
            ST_FEAT_OK:
            begin
                if ((sh_status & ST_DRIVER[7:0]) && shadow_cfg.features_accepted)
                    sh_status = sh_status | ST_FEAT_OK[7:0];
                return 1;
            end
            ST_DRIVER_OK:
            begin
                sh_status = sh_status | ST_DRIVER_OK[7:0];
                return 1;
            end
            ST_FAILED: return 1;
            default: return 0;
        endcase
    endfunction

    function automatic bit shadow_read(logic [11:0] off, ref logic [31:0] v);
        if (off <= 12'h003) begin v = MMIO_MAGIC; return 1; end
        if (off <= 12'h007) begin v = MMIO_VERSION; return 1; end
        if (off <= 12'h00B) begin v = shadow_cfg.device_id; return 1; end
        if (off <= 12'h00F) begin v = shadow_cfg.vendor_id; return 1; end
        if (off <= 12'h013)
        begin
            if (sh_dev_fsel == 0) begin v = shadow_cfg.device_features_low; return 1; end
            if (sh_dev_fsel == 1) begin v = shadow_cfg.device_features_high; return 1; end
            return 0;
        end
        if (off >= 12'h034 && off <= 12'h037) begin v = QUEUE_MAX_SIZE_DEF; return 1; end
        if (off >= 12'h044 && off <= 12'h04F)
        begin
            if (!shadow_sel_valid()) return 0;
            v = {31'd0, sh_qready[sh_qsel[2:0]]};
            return 1;
        end
        if (off >= 12'h060 && off <= 12'h063) begin v = sh_irq; return 1; end
        if (off >= 12'h070 && off <= 12'h07F) begin v = {24'd0, sh_status}; return 1; end
        if (off >= 12'h0FC && off <= 12'h0FF) begin v = shadow_cfg.config_generation; return 1; end
        return 0;
    endfunction

    function automatic bit shadow_write(logic [11:0] off, logic [31:0] d, ref bit ntf, ref bit rst);
        bit valid;
        int q;
        valid = shadow_sel_valid();
        q = valid ? int'(sh_qsel[2:0]) : 0;
        // ring registers of a ready queue are locked
        if (valid && sh_qready[q] &&
            ((off >= 12'h038 && off < 12'h044) || (off >= 12'h080 && off < 12'h0FC)))
            return 0;
        if (off >= 12'h014 && off <= 12'h01F) begin sh_dev_fsel = d; return 1; end
        if (off >= 12'h020 && off <= 12'h023)
        begin
            if (sh_drv_fsel > 1) return 0;
            sh_drv_feat[sh_drv_fsel[0]] = d;
            return 1;
        end
        if (off >= 12'h024 && off <= 12'h02F) begin sh_drv_fsel = d; return 1; end
        if (off >= 12'h030 && off <= 12'h033) begin sh_qsel = d; return 1; end
        if (off >= 12'h038 && off <= 12'h043)
        begin
            if (!valid) return 0;
            sh_qlen[q] = d;
            return 1;
        end
        if (off >= 12'h044 && off <= 12'h04F)
        begin
            // anything but 1 is ignored, still ok
            if (d == 1)
            begin
                if (!valid) return 0;
                sh_qready[q] = 1'b1;
            end
            return 1;
        end
        if (off >= 12'h050 && off <= 12'h05F) begin sh_notify = d; ntf = 1; return 1; end
        if (off >= 12'h064 && off <= 12'h06F) begin sh_irq = sh_irq & ~d; return 1; end
        if (off >= 12'h070 && off <= 12'h07F) return shadow_status_write(d, rst);
        if (off >= 12'h080 && off <= 12'h0FB)
        begin
            if (!valid) return 0;
            if (off <= 12'h083) sh_desc[q][31:0] = d;
            else if (off <= 12'h08F) sh_desc[q][63:32] = d;
            else if (off <= 12'h093) sh_avail[q][31:0] = d;
            else if (off <= 12'h09F) sh_avail[q][63:32] = d;
            else if (off <= 12'h0A3) sh_used[q][31:0] = d;
            else sh_used[q][63:32] = d;
            return 1;
        end
        return 0;
    endfunction

    // response that one accepted item should produce
    function automatic result_t mmio_predict(item_t it);
        result_t r;
        logic [31:0] rd;
        bit ok, ntf, rst;
        rd = '0;
        ok = 0;
        ntf = 0;
        rst = 0;
        if (it.mode == MODE_READ)
        begin
            ok = shadow_read(it.offset, rd);
            if (!ok) rd = '0;
        end
        else if (it.mode == MODE_WRITE)
            ok = shadow_write(it.offset, it.wdata, ntf, rst);
        else if (it.mode == MODE_RAISE)
        begin
            sh_irq = sh_irq | it.wdata;
            ok = 1;
        end
        r.rdata = rd;
        r.ok = ok;
        r.notify_pulse = ntf;
        r.notify_value = ntf ? sh_notify : '0;
        r.reset_pulse = rst;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // monitor: check responses, then record the item taken this edge
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        result_t pred;
        item_t   it;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got.rdata = rsp.rdata;
            got.ok = rsp.ok;
            got.notify_pulse = rsp.notify_pulse;
            got.notify_value = rsp.notify_value;
            got.reset_pulse = rsp.reset_pulse;
            rsp_checked++;
            if (rsp_expected.size() == 0)
            begin
                $error("response item with nothing expected");
                errors++;
            end
            else
            begin
                want = rsp_expected.pop_front();
                if (got.rdata !== want.rdata)
                begin
                    $error("rdata: expected %h, got %h", want.rdata, got.rdata);
                    errors++;
                end
                if (got.ok !== want.ok)
                begin
                    $error("ok: expected %b, got %b", want.ok, got.ok);
                    errors++;
                end
                if (got.notify_pulse !== want.notify_pulse)
                begin
                    $error("notify_pulse: expected %b, got %b",
                           want.notify_pulse, got.notify_pulse);
                    errors++;
                end
                if (got.notify_value !== want.notify_value)
                begin
                    $error("notify_value: expected %h, got %h",
                           want.notify_value, got.notify_value);
                    errors++;
                end
                if (got.reset_pulse !== want.reset_pulse)
                begin
                    $error("reset_pulse: expected %b, got %b",
                           want.reset_pulse, got.reset_pulse);
                    errors++;
                end
            end
        end
        if (rst_n && req.valid && req.ready)
        begin
            it.mode = req.mode;
            it.offset = req.offset;
            it.wdata = req.wdata;
            // the predictor always runs so its state keeps step
            pred = mmio_predict(it);
            rsp_expected.push_back(cur_typed ? cur_exp : pred);
        end
    end

    // ---------------------------------------------------------------
    // response side: random stalls, plus a long hold-off on request
    // ---------------------------------------------------------------
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 0;
                rsp.ready <= 1'b0;
                repeat (300) @(negedge clk);
            end
            rsp.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // offer one item and wait until it is taken
    task automatic send_item(item_t it, bit typed = 0, result_t exp = '0);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.mode <= it.mode;
        req.offset <= it.offset;
        req.wdata <= it.wdata;
        cur_typed = typed;
        cur_exp = exp;
        do @(posedge clk); while (!(req.valid && req.ready));
        items_sent++;
    endtask

    task automatic mmio_wr(logic [11:0] off, logic [31:0] d);
        send_item('{MODE_WRITE, off, d});
    endtask

    task automatic mmio_rd(logic [11:0] off);
        send_item('{MODE_READ, off, 32'd0});
    endtask

    // stop offering and let the block drain
    task automatic drain();
        @(negedge clk);
        req.valid <= 1'b0;
        cur_typed = 0;
        wait (rsp_expected.size() == 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        case (idx)
            CFG_DEVICE_ID:         shadow_cfg.device_id = v;
            CFG_VENDOR_ID:         shadow_cfg.vendor_id = v;
            CFG_DEV_FEATURES_LOW:  shadow_cfg.device_features_low = v;
            CFG_DEV_FEATURES_HIGH: shadow_cfg.device_features_high = v;
            CFG_QUEUES_IN_USE:     shadow_cfg.queues_in_use = v[3:0];
            CFG_FEATURES_ACCEPTED: shadow_cfg.features_accepted = v[0];
            CFG_CONFIG_GENERATION: shadow_cfg.config_generation = v;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic cfg_all(logic [31:0] ids, logic [3:0] nq, bit fa);
        cfg_write(CFG_DEVICE_ID, ids);
        cfg_write(CFG_VENDOR_ID, ~ids);
        cfg_write(CFG_DEV_FEATURES_LOW, $urandom);
        cfg_write(CFG_DEV_FEATURES_HIGH, ids ^ 32'h5a5a_0f0f);
        cfg_write(CFG_QUEUES_IN_USE, {28'd0, nq});
        cfg_write(CFG_FEATURES_ACCEPTED, {31'd0, fa});
        cfg_write(CFG_CONFIG_GENERATION, ~ids ^ $urandom);
    endtask

    // offsets at the start of each register span and one past the map, jittered by up to three
    localparam int NKEY = 24;
    logic [11:0] key_off [NKEY] = '{12'h000, 12'h004, 12'h008, 12'h00C, 12'h010, 12'h014,
                                   12'h020, 12'h024, 12'h030, 12'h034, 12'h038, 12'h044,
                                   12'h050, 12'h060, 12'h064, 12'h070, 12'h080, 12'h084,
                                   12'h090, 12'h094, 12'h0A0, 12'h0A4, 12'h0FC, 12'h100};

    function automatic logic [31:0] pick_data();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'hffff_ffff;
            2: return {24'd0, ST_ACK[7:0] | ($urandom_range(1) ? ST_DRIVER[7:0] : 8'd0) |
                        ($urandom_range(1) ? ST_FEAT_OK[7:0] : 8'd0) |
                        ($urandom_range(1) ? ST_DRIVER_OK[7:0] : 8'd0) |
                        ($urandom_range(3) == 0 ? ST_FAILED[7:0] : 8'd0)};
            3: return $urandom_range(9);
            4: return 32'd1;
            default: return 32'd0;
        endcase
    endfunction

    task automatic noise_item();
        item_t it;
        it.mode = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
        if ($urandom_range(7) == 0)
            it.offset = 12'($urandom_range(4095));
        else
            it.offset = key_off[$urandom_range(NKEY - 1)] + 12'($urandom_range(3));
        it.wdata = pick_data();
        send_item(it);
    endtask

    // a driver bring-up with random content: handshake, queues, traffic
    task automatic bringup_sequence();
        int nq;
        mmio_wr(12'h070, 32'd0);
        mmio_wr(12'h070, ST_ACK);
        mmio_wr(12'h070, ST_ACK | ST_DRIVER);
        mmio_wr(12'h014, $urandom_range(1));
        mmio_rd(12'h010);
        mmio_wr(12'h024, $urandom_range(2));
        mmio_wr(12'h020, $urandom);
        mmio_wr(12'h070, ST_ACK | ST_DRIVER | ST_FEAT_OK);
        mmio_rd(12'h070);
        nq = $urandom_range(2, 1);
        for (int k = 0; k < nq; k++)
        begin
            mmio_wr(12'h030, $urandom_range(NQ));
            mmio_rd(12'h044);
            mmio_wr(12'h038, $urandom_range(QUEUE_MAX_SIZE_DEF));
            mmio_wr(12'h080, $urandom);
            mmio_wr(12'h084, $urandom);
            mmio_wr(12'h090, $urandom);
            mmio_wr(12'h094, $urandom);
            mmio_wr(12'h0A0, $urandom);
            mmio_wr(12'h0A4, $urandom);
            mmio_wr(12'h044, 32'd1);
            mmio_wr(12'h080 + 12'($urandom_range(3) * 4), $urandom);
        end
        mmio_wr(12'h070, ST_ACK | ST_DRIVER | ST_FEAT_OK | ST_DRIVER_OK);
        repeat ($urandom_range(4, 1))
        begin
            mmio_wr(12'h050, $urandom);
            send_item('{MODE_RAISE, 12'($urandom), $urandom});
            mmio_rd(12'h060);
            mmio_wr(12'h064, $urandom);
        end
        if ($urandom_range(3) == 0) mmio_wr(12'h070, 32'd0);
    endtask

    task automatic random_phase(int n_items);
        int stop;
        stop = items_sent + n_items;
        while (items_sent < stop)
        begin
            if ($urandom_range(9) < 6)
                bringup_sequence();
            else
                repeat (8) noise_item();
        end
    endtask

    // directed stimulus: item plus expected response where it is obvious
    typedef struct {
        item_t   it;
        bit      typed;
        result_t exp;
    } dir_row_t;

    dir_row_t dir_rows [] = '{
        '{'{MODE_READ,  12'h000, 32'd0}, 1, '{MMIO_MAGIC, 1'b1, 1'b0, 32'd0, 1'b0}},
        '{'{MODE_READ,  12'h007, 32'd0}, 1, '{MMIO_VERSION, 1'b1, 1'b0, 32'd0, 1'b0}},
        '{'{MODE_READ,  12'h008, 32'd0}, 1, '{32'd0, 1'b1, 1'b0, 32'd0, 1'b0}},
        '{'{MODE_READ,  12'h034, 32'd0}, 1, '{32'd256, 1'b1, 1'b0, 32'd0, 1'b0}},
        '{'{MODE_READ,  12'h0FF, 32'd0}, 1, '{32'd0, 1'b1, 1'b0, 32'd0, 1'b0}},
        // device config space and the far end of the window
        '{'{MODE_READ,  12'h100, 32'd0}, 1, '{32'd0, 1'b0, 1'b0, 32'd0, 1'b0}},
        '{'{MODE_READ,  12'hFFF, 32'd0}, 1, '{32'd0, 1'b0, 1'b0, 32'd0, 1'b0}},
        // undefined mode and a write to a read-only register
        '{'{2'd3,       12'h000, 32'hffff_ffff}, 1, '{32'd0, 1'b0, 1'b0, 32'd0, 1'b0}},
        '{'{MODE_WRITE, 12'h000, 32'hffff_ffff}, 1, '{32'd0, 1'b0, 1'b0, 32'd0, 1'b0}},
        '{'{MODE_RAISE, 12'hFFF, 32'hffff_ffff}, 1, '{32'd0, 1'b1, 1'b0, 32'd0, 1'b0}},
        '{'{MODE_READ,  12'h060, 32'd0}, 1, '{32'hffff_ffff, 1'b1, 1'b0, 32'd0, 1'b0}},
        '{'{MODE_WRITE, 12'h064, 32'h0000_ffff}, 0, '0},
        '{'{MODE_READ,  12'h060, 32'd0}, 0, '0},
        '{'{MODE_WRITE, 12'h050, 32'hdead_beef}, 1, '{32'd0, 1'b1, 1'b1, 32'hdead_beef, 1'b0}},
        // handshake in order, then a bad transition and a driver reset
        '{'{MODE_WRITE, 12'h070, 32'h01}, 0, '0},
        '{'{MODE_WRITE, 12'h070, 32'h03}, 0, '0},
        '{'{MODE_WRITE, 12'h07F, 32'h0B}, 0, '0},
        '{'{MODE_WRITE, 12'h070, 32'h8F}, 0, '0},
        '{'{MODE_WRITE, 12'h070, 32'h30}, 0, '0},
        '{'{MODE_WRITE, 12'h070, 32'h00}, 1, '{32'd0, 1'b1, 1'b0, 32'd0, 1'b1}},
        // feature selector above 1
        '{'{MODE_WRITE, 12'h014, 32'd2}, 0, '0},
        '{'{MODE_READ,  12'h010, 32'd0}, 1, '{32'd0, 1'b0, 1'b0, 32'd0, 1'b0}},
        // ready queue locks its ring registers; bad selector
        '{'{MODE_WRITE, 12'h044, 32'd1}, 0, '0},
        '{'{MODE_WRITE, 12'h038, 32'd16}, 1, '{32'd0, 1'b0, 1'b0, 32'd0, 1'b0}},
        '{'{MODE_WRITE, 12'h030, 32'hffff_ffff}, 0, '0},
        '{'{MODE_READ,  12'h044, 32'd0}, 1, '{32'd0, 1'b0, 1'b0, 32'd0, 1'b0}}
    };

    initial
    begin
        req.valid = 1'b0;
        req.mode = '0;
        req.offset = '0;
        req.wdata = '0;
        shadow_cfg = '{32'd0, 32'd0, 32'd0, 32'd0, 4'd1, 1'b1, 32'd0};
        sh_status = '0;
        sh_irq = '0;
        sh_dev_fsel = '0;
        sh_drv_fsel = '0;
        sh_drv_feat = '{32'd0, 32'd0};
        sh_qsel = '0;
        sh_notify = '0;
        foreach (sh_qready[i])
        begin
            sh_qready[i] = 1'b0;
            sh_qlen[i] = '0;
            sh_desc[i] = '0;
            sh_avail[i] = '0;
            sh_used[i] = '0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part, reset configuration, no idling
        foreach (dir_rows[i])
            send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].exp);
        drain();

        // all queues live, all-ones device id and zero vendor id, steady flow
        cfg_all(32'hffff_ffff, 4'd8, 1'b1);
        random_phase(450);
        drain();

        // no queues, features refused, sender mostly idle
        src_idle_pct = 62;
        cfg_all(32'd0, 4'd0, 1'b0);
        random_phase(450);
        drain();

        // selector count beyond the queue array, receiver stalling;
        // a long hold-off fills the block while items keep coming
        src_idle_pct = 0;
        snk_idle_pct = 62;
        cfg_all($urandom, 4'd15, 1'b1);
        long_hold_req = 1;
        random_phase(450);
        // sender pauses until every response is in, then resumes
        drain();
        random_phase(50);
        drain();

        // random setup, both sides idling
        src_idle_pct = 28;
        snk_idle_pct = 28;
        cfg_all($urandom, 4'($urandom_range(1, 7)), 1'($urandom_range(1)));
        random_phase(450);
        drain();

        $display("run covered %0d request items and %0d response items over five setups",
                 items_sent, rsp_checked);
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
